FILE: hw/rtl/nstp_pkg.sv
// ----------------------------------------------------------------------------
// nstp_pkg
// Shared constants, codes and types of the nested state time profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package nstp_pkg;

  localparam int EVENTS   = 64;
  localparam int RANKS    = 16;
  localparam int NEST_MAX = 255;

  localparam int EW    = $clog2(EVENTS);
  localparam int RW    = $clog2(RANKS);
  localparam int SLOTS = EVENTS * RANKS;
  localparam int SW    = $clog2(SLOTS);

  localparam int TS_W    = 48;
  localparam int TOT_W   = 56;
  localparam int CALL_W  = 32;
  localparam int NEST_W  = 8;
  localparam int ID_W    = 6;
  localparam int RANK_W  = 4;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 3;

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_START  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SOLO   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REPORT = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_CLOSED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNMATCH  = 3'd4;
  localparam logic [STAT_W-1:0] ST_CUTOFF   = 3'd5;
  localparam logic [STAT_W-1:0] ST_REPORT   = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_RANK_ANY    = 2'd0;
  localparam logic [1:0] CFG_RANK_SELECT = 2'd1;
  localparam logic [1:0] CFG_CUT_EN      = 2'd2;
  localparam logic [1:0] CFG_CUT_TIME    = 2'd3;

  typedef enum logic [1:0] {
    OP_START,
    OP_STOP,
    OP_SOLO,
    OP_BADSTOP
  } op_t;

  typedef struct packed {
    logic            is_report;
    logic            cut;
    logic            ignored;
    op_t             op;
    logic            ev_ok;
    logic [ID_W-1:0] ev_id;
    logic [ID_W-1:0] res_ev;
    logic [EW-1:0]   ev_addr;
    logic [SW-1:0]   slot;
    logic [TS_W-1:0] ts;
  } item_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_SW_RD,
    BK_SW_CALC,
    BK_SW_ADD,
    BK_FIN
  } bk_state_t;

  function automatic logic [TS_W-1:0] span(input logic [TS_W-1:0] now,
                                           input logic [TS_W-1:0] then_t);
    span = (now >= then_t) ? (now - then_t) : '0;
  endfunction

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] tot,
                                               input logic [TS_W-1:0] d);
    logic [TOT_W:0] s;
    s = {1'b0, tot} + {{(TOT_W - TS_W + 1){1'b0}}, d};
    sat_add = s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nstp_ram.sv
// ----------------------------------------------------------------------------
// nstp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nstp_fifo.sv
// ----------------------------------------------------------------------------
// nstp_fifo
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module nstp_fifo import nstp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output item_t      head
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nstp_front.sv
// ----------------------------------------------------------------------------
// nstp_front
// Holds the configuration and classifies incoming log events into queue items.
// ----------------------------------------------------------------------------
`default_nettype none

module nstp_front import nstp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [TS_W-1:0]   cfg_wdata,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [ID_W-1:0]   event_id,
  input  wire logic [RANK_W-1:0] source_rank,
  input  wire logic [TS_W-1:0]   timestamp,
  output item_t                  item
);

  logic              rank_any_r;
  logic [RANK_W-1:0] rank_select_r;
  logic              cut_en_r;
  logic [TS_W-1:0]   cut_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_any_r    <= 1'b1;
      rank_select_r <= '0;
      cut_en_r      <= 1'b0;
      cut_time_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RANK_ANY:    rank_any_r    <= cfg_wdata[0];
        CFG_RANK_SELECT: rank_select_r <= cfg_wdata[RANK_W-1:0];
        CFG_CUT_EN:      cut_en_r      <= cfg_wdata[0];
        CFG_CUT_TIME:    cut_time_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic            ev_ok;
  logic            rank_ok;
  logic            ign;
  logic [ID_W-1:0] ev_m1;

  always_comb begin
    ev_ok   = ({1'b0, event_id} < (ID_W + 1)'(EVENTS));
    rank_ok = ({1'b0, source_rank} < (RANK_W + 1)'(RANKS));
    ev_m1   = event_id - ID_W'(1);
    ign     = !ev_ok || !rank_ok ||
              (!rank_any_r && (source_rank != rank_select_r));

    item.is_report = (kind == KIND_REPORT);
    item.cut       = cut_en_r && (timestamp > cut_time_r) && (kind != KIND_REPORT);
    item.ev_ok     = ev_ok;
    item.ts        = timestamp;
    item.ev_id     = event_id;
    item.res_ev    = event_id;
    item.ev_addr   = event_id[EW-1:0];
    item.slot      = {event_id[EW-1:0], source_rank[RW-1:0]};
    item.ignored   = ign;
    case (kind)
      KIND_START: item.op = OP_START;
      KIND_SOLO:  item.op = OP_SOLO;
      KIND_STOP: begin
        if (event_id == '0) begin
          item.op = OP_BADSTOP;
        end else begin
          // A stop works on the slot of its start event.
          item.op   = OP_STOP;
          item.slot = {ev_m1[EW-1:0], source_rank[RW-1:0]};
          if (!ign) begin
            item.res_ev  = ev_m1;
            item.ev_addr = ev_m1[EW-1:0];
          end
        end
      end
      default: begin
        item.op      = OP_SOLO;
        item.ignored = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nstp_back.sv
// ----------------------------------------------------------------------------
// nstp_back
// Executes queued items against the nest, start, total and call memories,
// runs the reset clearing pass and the cutoff sweep, and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nstp_back import nstp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire item_t        q_head,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [ID_W-1:0]   out_event,
  output logic [TS_W-1:0]   out_duration,
  output logic [TOT_W-1:0]  out_total,
  output logic [CALL_W-1:0] out_calls
);

  bk_state_t state_r, state_nxt;
  item_t     cur_r;
  logic      halted_r, halted_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [TS_W-1:0] span_r;
  logic      run_r;
  logic      out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [ID_W-1:0]   out_event_r;
  logic [TS_W-1:0]   out_duration_r;
  logic [TOT_W-1:0]  out_total_r;
  logic [CALL_W-1:0] out_calls_r;

  // Memory ports
  logic              nest_we, start_we, tot_we, call_we;
  logic [SW-1:0]     slot_waddr, slot_raddr;
  logic [EW-1:0]     tot_waddr, call_waddr, ev_raddr;
  logic [NEST_W-1:0] nest_wdata, nest_rd;
  logic [TS_W-1:0]   start_wdata, start_rd;
  logic [TOT_W-1:0]  tot_wdata, tot_rd;
  logic [CALL_W-1:0] call_wdata, call_rd;

  nstp_ram #(.WIDTH(NEST_W), .DEPTH(SLOTS)) u_nest (
    .clk(clk), .we(nest_we), .waddr(slot_waddr), .wdata(nest_wdata),
    .raddr(slot_raddr), .rdata(nest_rd));
  nstp_ram #(.WIDTH(TS_W), .DEPTH(SLOTS)) u_start (
    .clk(clk), .we(start_we), .waddr(slot_waddr), .wdata(start_wdata),
    .raddr(slot_raddr), .rdata(start_rd));
  nstp_ram #(.WIDTH(TOT_W), .DEPTH(EVENTS)) u_total (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .raddr(ev_raddr), .rdata(tot_rd));
  nstp_ram #(.WIDTH(CALL_W), .DEPTH(EVENTS)) u_call (
    .clk(clk), .we(call_we), .waddr(call_waddr), .wdata(call_wdata),
    .raddr(ev_raddr), .rdata(call_rd));

  logic can_pop;
  assign can_pop   = !q_empty && (!out_valid_r || out_ready);
  assign clearing  = (state_r == BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_status   = out_status_r;
  assign out_event    = out_event_r;
  assign out_duration = out_duration_r;
  assign out_total    = out_total_r;
  assign out_calls    = out_calls_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR:   if (cnt_r == {SW{1'b1}}) state_nxt = BK_IDLE;
      BK_IDLE: begin
        if (can_pop) begin
          if (!q_head.is_report && !halted_r && q_head.cut) begin
            state_nxt = BK_SW_RD;
          end else begin
            state_nxt = BK_READ;
          end
        end
      end
      BK_READ:    state_nxt = BK_IDLE;
      BK_SW_RD:   state_nxt = BK_SW_CALC;
      BK_SW_CALC: state_nxt = BK_SW_ADD;
      BK_SW_ADD:  state_nxt = (cnt_r == {SW{1'b1}}) ? BK_FIN : BK_SW_RD;
      BK_FIN:     state_nxt = BK_READ;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  logic              load;
  logic [STAT_W-1:0] st;
  logic [TS_W-1:0]   dur;
  logic [TOT_W-1:0]  tot_new;
  logic [CALL_W-1:0] call_new;
  logic [NEST_W-1:0] nest_dec;

  // Outputs and memory control
  always_comb begin
    q_pop       = 1'b0;
    load        = 1'b0;
    halted_nxt  = halted_r;
    cnt_nxt     = cnt_r;
    nest_we     = 1'b0;
    start_we    = 1'b0;
    tot_we      = 1'b0;
    call_we     = 1'b0;
    slot_waddr  = cur_r.slot;
    tot_waddr   = cur_r.ev_addr;
    call_waddr  = cur_r.ev_addr;
    nest_wdata  = '0;
    start_wdata = '0;
    tot_wdata   = '0;
    call_wdata  = '0;
    slot_raddr  = cnt_r;
    ev_raddr    = cnt_r[SW-1:RW];
    st          = ST_IGNORED;
    dur         = '0;
    tot_new     = tot_rd;
    call_new    = call_rd;
    nest_dec    = nest_rd - NEST_W'(1);
    unique case (state_r)
      BK_CLEAR: begin
        nest_we    = 1'b1;
        start_we   = 1'b1;
        tot_we     = 1'b1;
        call_we    = 1'b1;
        slot_waddr = cnt_r;
        tot_waddr  = cnt_r[EW-1:0];
        call_waddr = cnt_r[EW-1:0];
        cnt_nxt    = cnt_r + SW'(1);
      end
      BK_IDLE: begin
        q_pop      = can_pop;
        slot_raddr = q_head.slot;
        // A halted or cutting item reports the totals of its own event id.
        ev_raddr   = (halted_r || q_head.cut) ? q_head.ev_id[EW-1:0] : q_head.ev_addr;
        cnt_nxt    = '0;
      end
      BK_READ: begin
        load = 1'b1;
        if (cur_r.is_report) begin
          st = ST_REPORT;
        end else if (halted_r) begin
          st = ST_CUTOFF;
        end else if (cur_r.ignored) begin
          st = ST_IGNORED;
        end else begin
          case (cur_r.op)
            OP_START: begin
              if (nest_rd >= NEST_W'(NEST_MAX)) begin
                st = ST_OVERFLOW;
              end else begin
                st         = ST_ACCEPTED;
                call_new   = (call_rd == {CALL_W{1'b1}}) ? call_rd : call_rd + CALL_W'(1);
                call_we    = 1'b1;
                call_wdata = call_new;
                nest_we    = 1'b1;
                nest_wdata = nest_rd + NEST_W'(1);
                if (nest_rd == '0) begin
                  start_we    = 1'b1;
                  start_wdata = cur_r.ts;
                end
              end
            end
            OP_STOP: begin
              if (nest_rd == '0) begin
                st = ST_UNMATCH;
              end else begin
                nest_we    = 1'b1;
                nest_wdata = nest_dec;
                if (nest_dec != '0) begin
                  st = ST_ACCEPTED;
                end else begin
                  // Outermost level closed: add the interval to the total.
                  st          = ST_CLOSED;
                  dur         = span(cur_r.ts, start_rd);
                  tot_new     = sat_add(tot_rd, dur);
                  tot_we      = 1'b1;
                  tot_wdata   = tot_new;
                  start_we    = 1'b1;
                  start_wdata = '0;
                end
              end
            end
            OP_BADSTOP: st = ST_UNMATCH;
            default: begin
              st         = ST_ACCEPTED;
              call_new   = (call_rd == {CALL_W{1'b1}}) ? call_rd : call_rd + CALL_W'(1);
              call_we    = 1'b1;
              call_wdata = call_new;
            end
          endcase
        end
        if (!cur_r.ev_ok) begin
          tot_new  = '0;
          call_new = '0;
        end
      end
      BK_SW_RD, BK_SW_CALC: ;
      BK_SW_ADD: begin
        tot_waddr = cnt_r[SW-1:RW];
        tot_we    = run_r;
        tot_wdata = sat_add(tot_rd, span_r);
        cnt_nxt   = cnt_r + SW'(1);
        if (cnt_r == {SW{1'b1}}) begin
          halted_nxt = 1'b1;
        end
      end
      BK_FIN: begin
        slot_raddr = cur_r.slot;
        ev_raddr   = cur_r.ev_id[EW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      halted_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      halted_r    <= halted_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (state_r == BK_SW_CALC) begin
      span_r <= span(cur_r.ts, start_rd);
      run_r  <= (nest_rd != '0);
    end
    if (load) begin
      out_status_r   <= st;
      out_event_r    <= halted_r ? cur_r.ev_id : cur_r.res_ev;
      out_duration_r <= dur;
      out_total_r    <= tot_new;
      out_calls_r    <= call_new;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nested_state_time_profiler.sv
// ----------------------------------------------------------------------------
// nested_state_time_profiler
// Nested interval profiler for timestamped log events.
// ----------------------------------------------------------------------------
// Log events enter on the in_ stream (kind on in_tuser) and each produces
// exactly one result item on the out_ stream (status on out_tuser), in order.
// Registers must be written through the cfg_ port only while the block is
// idle; the block itself does not enforce this. A front part decodes and
// filters each item and pushes it into a two-entry queue; a back part pops
// it, reads the nest, start, total and call memories (BK_IDLE), then updates
// them and registers the result (BK_READ), taking no new item before that
// read-modify-write is through. After reset a clearing pass steps through
// all 1024 slots and zeroes all memories, during which in_tready is low. An
// item that crosses the enabled cutoff starts a sweep over all 1024 slots,
// each through BK_SW_RD, BK_SW_CALC and BK_SW_ADD, before its result appears.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and in_tready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_state_time_profiler import nstp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [47:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // event_id, source_rank, timestamp, zeros
  input  wire logic [2:0]   in_tuser,   // kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata,  // result_event, duration, total_time,
                                        // call_count, zeros
  output logic [2:0]        out_tuser   // status
);

  item_t item, head;
  logic  push, pop, full, empty, clearing;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   res_ev;
  logic [TS_W-1:0]   duration;
  logic [TOT_W-1:0]  total;
  logic [CALL_W-1:0] calls;

  assign in_tready = !full && !clearing;
  assign push      = in_tvalid && in_tready;

  nstp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .kind(in_tuser), .event_id(in_tdata[5:0]), .source_rank(in_tdata[9:6]),
    .timestamp(in_tdata[57:10]), .item(item));

  nstp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(item), .pop(pop),
    .full(full), .empty(empty), .head(head));

  nstp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_head(head), .q_pop(pop),
    .clearing(clearing), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(status), .out_event(res_ev), .out_duration(duration),
    .out_total(total), .out_calls(calls));

  assign out_tuser = status;
  assign out_tdata = {2'b00, calls, total, duration, res_ev};

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Nested state time profiler testbench
// Streams timestamped start, stop, solo, report and noise items into the
// profiler under random burst and stall patterns. A predictor inside the
// bench tracks nesting, start times, totals and call counts and checks every
// result item field by field. Settings change between phases, and the
// cutoff phase comes last because it halts the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import nstp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd3;
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};
  localparam logic [CALL_W-1:0] CALL_MAX = {CALL_W{1'b1}};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   ev;
    logic [RANK_W-1:0] rank;
    logic [TS_W-1:0]   ts;
  } log_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   ev;
    logic [TS_W-1:0]   dur;
    logic [TOT_W-1:0]  tot;
    logic [CALL_W-1:0] calls;
  } profile_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [47:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;   // event_id, source_rank, timestamp, zeros
  logic [2:0]   in_tuser = '0;   // kind
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [143:0] out_tdata;       // result_event, duration, total_time, call_count, zeros
  logic [2:0]   out_tuser;       // status

  nested_state_time_profiler u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // Shadow state of the profiler
  logic [NEST_W-1:0] nest_lv [SLOTS];
  logic [TS_W-1:0]   open_ts [SLOTS];
  logic [TOT_W-1:0]  tot_time [EVENTS];
  logic [CALL_W-1:0] call_cnt [EVENTS];
  logic              is_halted = 1'b0;
  logic              any_rank = 1'b1;
  logic [RANK_W-1:0] sel_rank = '0;
  logic              cut_en = 1'b0;
  logic [TS_W-1:0]   cut_ts = '0;

  log_item_t pending_items[$];
  profile_t  pending_results[$];
  int errors = 0;
  int items_in = 0;
  int results_out = 0;
  logic [TS_W-1:0] now_ts = '0;
  bit cutoff_phase = 0;

  function automatic profile_t totals_of(logic [STAT_W-1:0] st, logic [ID_W-1:0] ev,
                                         logic [TS_W-1:0] dur);
    profile_t r;
    r.status = st;
    r.ev = ev;
    r.dur = dur;
    r.tot = tot_time[ev];
    r.calls = call_cnt[ev];
    return r;
  endfunction

  function automatic logic [TS_W-1:0] elapsed(logic [TS_W-1:0] t1, logic [TS_W-1:0] t0);
    return (t1 >= t0) ? t1 - t0 : '0;
  endfunction

  function automatic void accumulate(logic [ID_W-1:0] ev, logic [TS_W-1:0] d);
    logic [TOT_W:0] s;
    s = {1'b0, tot_time[ev]} + d;
    tot_time[ev] = s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
  endfunction

  function automatic void bump_calls(logic [ID_W-1:0] ev);
    if (call_cnt[ev] != CALL_MAX) call_cnt[ev] = call_cnt[ev] + CALL_W'(1);
  endfunction

  function automatic profile_t profile_event(log_item_t it);
    logic [SW-1:0] k;
    logic [ID_W-1:0] s;
    logic [TS_W-1:0] d;
    if (it.kind == KIND_REPORT) return totals_of(ST_REPORT, it.ev, '0);
    if (is_halted) return totals_of(ST_CUTOFF, it.ev, '0);
    if (cut_en && it.ts > cut_ts) begin
      // Close every open interval at this timestamp.
      for (int i = 0; i < SLOTS; i++) begin
        if (nest_lv[i] != 0) accumulate(ID_W'(i / RANKS), elapsed(it.ts, open_ts[i]));
      end
      is_halted = 1'b1;
      return totals_of(ST_CUTOFF, it.ev, '0);
    end
    if (it.kind > KIND_SOLO) return totals_of(ST_IGNORED, it.ev, '0);
    if (!any_rank && it.rank != sel_rank) return totals_of(ST_IGNORED, it.ev, '0);
    if (it.kind == KIND_START) begin
      k = {it.ev, it.rank};
      if (nest_lv[k] >= NEST_MAX) return totals_of(ST_OVERFLOW, it.ev, '0);
      bump_calls(it.ev);
      if (nest_lv[k] == 0) open_ts[k] = it.ts;
      nest_lv[k] = nest_lv[k] + NEST_W'(1);
      return totals_of(ST_ACCEPTED, it.ev, '0);
    end
    if (it.kind == KIND_STOP) begin
      if (it.ev == 0) return totals_of(ST_UNMATCH, '0, '0);
      s = it.ev - ID_W'(1);
      k = {s, it.rank};
      if (nest_lv[k] == 0) return totals_of(ST_UNMATCH, s, '0);
      nest_lv[k] = nest_lv[k] - NEST_W'(1);
      if (nest_lv[k] != 0) return totals_of(ST_ACCEPTED, s, '0);
      d = elapsed(it.ts, open_ts[k]);
      accumulate(s, d);
      open_ts[k] = '0;
      return totals_of(ST_CLOSED, s, d);
    end
    bump_calls(it.ev);
    return totals_of(ST_ACCEPTED, it.ev, '0);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    log_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (burst_left > 0 && pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {6'b0, it.ts, it.rank, it.ev};
        in_tuser <= it.kind;
        burst_left--;
      end else begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver stall pattern: one of four modes, redrawn periodically.
  int cyc = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    cyc++;
    if (cyc % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 9) < 7);
      2: out_tready <= (cyc % 5 != 0);
      default: out_tready <= (cyc % 50 >= 20);
    endcase
  end

  // Monitor: check results first, then record the item accepted at this edge.
  always @(posedge clk) begin
    profile_t got, want;
    log_item_t it;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_out++;
        got.status = out_tuser;
        got.ev = out_tdata[5:0];
        got.dur = out_tdata[53:6];
        got.tot = out_tdata[109:54];
        got.calls = out_tdata[141:110];
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            errors++;
          end
          if (got.ev !== want.ev) begin
            $error("result_event expected %0d got %0d", want.ev, got.ev);
            errors++;
          end
          if (got.dur !== want.dur) begin
            $error("duration expected %0h got %0h", want.dur, got.dur);
            errors++;
          end
          if (got.tot !== want.tot) begin
            $error("total_time expected %0h got %0h", want.tot, got.tot);
            errors++;
          end
          if (got.calls !== want.calls) begin
            $error("call_count expected %0d got %0d", want.calls, got.calls);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        items_in++;
        it.kind = in_tuser;
        it.ev = in_tdata[5:0];
        it.rank = in_tdata[9:6];
        it.ts = in_tdata[57:10];
        pending_results.push_back(profile_event(it));
      end
    end
  end

  task automatic push_item(logic [KIND_W-1:0] kind, logic [ID_W-1:0] ev,
                           logic [RANK_W-1:0] rank, logic [TS_W-1:0] ts);
    log_item_t it;
    it.kind = kind;
    it.ev = ev;
    it.rank = rank;
    it.ts = ts;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RANK_ANY:    any_rank = val[0];
      CFG_RANK_SELECT: sel_rank = val[RANK_W-1:0];
      CFG_CUT_EN:      cut_en = val[0];
      default:         cut_ts = val;
    endcase
  endtask

  function automatic logic [TS_W-1:0] tick();
    now_ts = now_ts + $urandom_range(0, 5000);
    return now_ts;
  endfunction

  // Mostly well-formed nested start/stop sequences, plus reports and noise.
  task automatic random_items(int n);
    int made, depth, pick;
    logic [ID_W-1:0] e;
    logic [RANK_W-1:0] r;
    logic [TS_W-1:0] t;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        e = $urandom_range(0, EVENTS - 2);
        r = (!any_rank && $urandom_range(0, 9) < 7) ? sel_rank : $urandom_range(0, 15);
        depth = $urandom_range(1, 4);
        for (int i = 0; i < depth; i++) push_item(KIND_START, e, r, tick());
        if ($urandom_range(0, 2) == 0) push_item(KIND_SOLO, $urandom_range(0, 63), r, tick());
        for (int i = 0; i < depth; i++) begin
          // Now and then a stop carries a timestamp from the past.
          t = ($urandom_range(0, 9) == 0) ? TS_W'($urandom_range(0, 1000)) : tick();
          push_item(KIND_STOP, e + 1, r, t);
        end
        made += 2 * depth;
      end else if (pick < 7) begin
        push_item(KIND_REPORT, $urandom_range(0, 63), $urandom_range(0, 15),
                  {$urandom, $urandom} );
        made++;
      end else begin
        t = cutoff_phase ? now_ts : {$urandom, $urandom};
        push_item($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 15), t);
        made++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      nest_lv[i] = '0;
      open_ts[i] = '0;
    end
    for (int i = 0; i < EVENTS; i++) begin
      tot_time[i] = '0;
      call_cnt[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every kind, backward time, nesting, unmatched stops.
    push_item(KIND_START, 0, 0, '0);
    push_item(KIND_STOP, 1, 0, TS_MAX);
    push_item(KIND_STOP, 0, 0, 100);
    push_item(KIND_STOP, 63, 15, 100);
    push_item(KIND_START, 63, 15, TS_MAX);
    push_item(KIND_START, 63, 15, TS_MAX);
    push_item(KIND_START, 10, 4, 1000);
    push_item(KIND_STOP, 11, 4, 500);
    push_item(KIND_SOLO, 62, 9, 1234);
    push_item(KIND_OTHER, 5, 5, 77);
    push_item(3'd5, 6, 6, 77);
    push_item(3'd6, 7, 7, 77);
    push_item(3'd7, 63, 15, TS_MAX);
    push_item(KIND_START, 20, 1, 100);
    push_item(KIND_START, 20, 1, 200);
    push_item(KIND_STOP, 21, 1, 300);
    push_item(KIND_STOP, 21, 1, 400);
    push_item(KIND_REPORT, 0, 15, TS_MAX);
    push_item(KIND_REPORT, 63, 0, 0);
    push_item(KIND_REPORT, 20, 3, 0);
    wait_idle();

    // Nest overflow, then unwinding past zero.
    for (int i = 0; i < NEST_MAX + 1; i++) push_item(KIND_START, 5, 3, tick());
    for (int i = 0; i < NEST_MAX + 1; i++) push_item(KIND_STOP, 6, 3, tick());
    // Drive one total into saturation with full-range intervals.
    for (int i = 0; i < 258; i++) begin
      push_item(KIND_START, 7, 2, '0);
      push_item(KIND_STOP, 8, 2, TS_MAX);
    end
    push_item(KIND_REPORT, 7, 0, 0);
    random_items(150);
    wait_idle();

    write_reg(CFG_RANK_ANY, 0);
    write_reg(CFG_RANK_SELECT, 15);
    write_reg(CFG_CUT_TIME, 0);
    random_items(120);
    wait_idle();

    write_reg(CFG_RANK_SELECT, 0);
    random_items(100);
    wait_idle();

    write_reg(CFG_RANK_SELECT, $urandom_range(1, 14));
    random_items(80);
    wait_idle();

    write_reg(CFG_RANK_ANY, 1);
    write_reg(CFG_CUT_TIME, TS_MAX);
    write_reg(CFG_CUT_EN, 1);
    random_items(120);
    wait_idle();

    // Cutoff: leave intervals open, cross the cutoff, then keep talking.
    cutoff_phase = 1;
    write_reg(CFG_CUT_TIME, now_ts + 48'h100_0000_0000);
    random_items(100);
    for (int i = 0; i < 12; i++) begin
      push_item(KIND_START, $urandom_range(0, 63), $urandom_range(0, 15), tick());
    end
    push_item(KIND_REPORT, 3, 0, TS_MAX);
    push_item($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 15), cut_ts + 1);
    for (int i = 0; i < 60; i++) begin
      push_item($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 15),
                {$urandom, $urandom});
    end
    wait_idle();

    $display("Checked %0d items and %0d results over rank filter and cutoff settings.",
             items_in, results_out);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/nstp_pkg.sv
hw/rtl/nstp_ram.sv
hw/rtl/nstp_fifo.sv
hw/rtl/nstp_front.sv
hw/rtl/nstp_back.sv
hw/rtl/nested_state_time_profiler.sv
bench/tb.sv
